// File: src/bvcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcl_pkg
// Shared types, constants and table helpers of the battery charge level block.
// ----------------------------------------------------------------------------
package bvcl_pkg;

  localparam int MAX_POINTS = 8;
  localparam int PT_IDX_W   = 3;
  localparam int RAW_W      = 16;
  localparam int MV_W       = 16;
  localparam int LEVEL_W    = 10;
  localparam int SCALE_W    = 24;
  localparam int TABLE_W    = 64;
  localparam int POINTS_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = RAW_W + SCALE_W;
  localparam int DIVD_W     = 2 * MV_W;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;

  localparam logic [MV_W-1:0]     MV_MAX       = 16'hFFFF;
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL   = 10'd1000;
  localparam logic [LEVEL_W-1:0]  LEVEL_EMPTY  = 10'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'h010000;
  localparam logic [POINTS_W-1:0] POINTS_RESET = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_SCALE   = 3'd0,
    REG_LOW_THRESH   = 3'd1,
    REG_VOLT_LOW     = 3'd2,
    REG_VOLT_HIGH    = 3'd3,
    REG_LEVEL_LOW    = 3'd4,
    REG_LEVEL_HIGH   = 3'd5,
    REG_POINTS_USED  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CLASS,
    ST_SEARCH,
    ST_PROD,
    ST_DIV_GO,
    ST_DIV,
    ST_STORE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [MV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [MV_W-1:0] table_entry(input logic [TABLE_W-1:0] lo,
                                                  input logic [TABLE_W-1:0] hi,
                                                  input logic [PT_IDX_W-1:0] k);
    logic [TABLE_W-1:0] word;
    word = k[PT_IDX_W-1] ? hi : lo;
    return word[{k[PT_IDX_W-2:0], 4'b0000} +: MV_W];
  endfunction

  function automatic logic [PT_IDX_W-1:0] last_index(input logic [POINTS_W-1:0] pu);
    logic [PT_IDX_W-1:0] idx;
    if (pu < 4'd2) begin
      idx = PT_IDX_W'(1);
    end else if (pu > POINTS_W'(MAX_POINTS)) begin
      idx = PT_IDX_W'(MAX_POINTS - 1);
    end else begin
      idx = PT_IDX_W'(pu - 4'd1);
    end
    return idx;
  endfunction

endpackage

// File: src/bvcl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcl_in_if
// Request channel carrying the two raw converter readings.
// ----------------------------------------------------------------------------
interface bvcl_in_if;
  import bvcl_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_a;
  logic [RAW_W-1:0] raw_b;

  modport source (output valid, output raw_a, output raw_b, input ready);
  modport sink   (input valid, input raw_a, input raw_b, output ready);
endinterface

// File: src/bvcl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcl_out_if
// Result channel carrying voltages, charge levels and low flags.
// ----------------------------------------------------------------------------
interface bvcl_out_if;
  import bvcl_pkg::*;

  logic               valid;
  logic               ready;
  logic [MV_W-1:0]    volts_a_mv;
  logic [LEVEL_W-1:0] level_a;
  logic               low_a;
  logic [MV_W-1:0]    volts_b_mv;
  logic [LEVEL_W-1:0] level_b;
  logic               low_b;

  modport source (output valid, output volts_a_mv, output level_a, output low_a,
                  output volts_b_mv, output level_b, output low_b, input ready);
  modport sink   (input valid, input volts_a_mv, input level_a, input low_a,
                  input volts_b_mv, input level_b, input low_b, output ready);
endinterface

// File: src/bvcl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcl_div
// Restoring divider, one quotient bit per cycle, for a 16-bit quotient.
// ----------------------------------------------------------------------------
module bvcl_div (
  input  logic               clk,
  input  logic               rst,
  input  bvcl_pkg::div_req_t req,
  output bvcl_pkg::div_rsp_t rsp
);
  import bvcl_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [MV_W-1:0]      rem;
  logic [MV_W-1:0]      quo;
  logic [MV_W-1:0]      dsr;
  logic [MV_W:0]        shifted;
  logic [MV_W:0]        diff;
  logic                 take;

  // The caller guarantees the quotient fits in 16 bits, so the upper half
  // of the dividend is already below the divisor.
  assign shifted = {rem, quo[MV_W-1]};
  assign take    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == '0);
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[DIVD_W-1:MV_W];
      quo <= req.dividend[MV_W-1:0];
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= take ? diff[MV_W-1:0] : shifted[MV_W-1:0];
      quo <= {quo[MV_W-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: src/battery_voltage_to_charge_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_to_charge_level
// Two-channel battery voltage scaling and charge level interpolation.
//
// A request on the sample channel carries two raw readings. Each is scaled to
// millivolts, compared with the low threshold and mapped to a charge level in
// tenths of a percent through the breakpoint table. One result per request
// leaves on the result channel. Both channels use valid and ready.
// The sequencer works through battery one and then battery two with a single
// multiplier, a breakpoint comparator stepped one point per cycle and a
// divider that yields one quotient bit per cycle. A reading clamped at either
// end of the table passes scale, classify and store; an interpolated one also
// passes the breakpoint search, the product, the divider start and the divide
// wait before store. Sample ready is high only while idle.
// The result register holds a finished result while the receiver stalls; the
// next request is taken meanwhile and waits at its end for the register.
// Configuration writes are taken at any time and should be made while idle.
// Synchronous reset restores the register defaults and empties both channels.
// ----------------------------------------------------------------------------
module battery_voltage_to_charge_level (
  input  logic                            clk,
  input  logic                            rst,
  bvcl_in_if.sink                         sample,
  bvcl_out_if.source                      result,
  input  logic                            cfg_we,
  input  logic [bvcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvcl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bvcl_pkg::*;

  logic [SCALE_W-1:0]  volt_scale_q16;
  logic [MV_W-1:0]     low_threshold_mv;
  logic [TABLE_W-1:0]  volt_points_low;
  logic [TABLE_W-1:0]  volt_points_high;
  logic [TABLE_W-1:0]  level_points_low;
  logic [TABLE_W-1:0]  level_points_high;
  logic [POINTS_W-1:0] points_used;

  state_t state;
  state_t state_next;

  logic                ch;
  logic [RAW_W-1:0]    raw_a;
  logic [RAW_W-1:0]    raw_b;
  logic [PROD_W-1:0]   prod;
  logic [MV_W-1:0]     mv;
  logic [PT_IDX_W-1:0] idx;
  logic [MV_W-1:0]     den;
  logic                neg;
  logic [LEVEL_W-1:0]  lvl;
  logic [MV_W-1:0]     keep_mv;
  logic [LEVEL_W-1:0]  keep_lvl;
  logic                keep_low;

  logic                out_valid;
  logic                out_load;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [MV_W-1:0]     mul_a;
  logic [SCALE_W-1:0]  mul_b;
  logic [MV_W-1:0]     mv_sat;
  logic [PT_IDX_W-1:0] idx_last;
  logic [PT_IDX_W-1:0] idx_prev;
  logic [MV_W-1:0]     v_sel;
  logic [MV_W-1:0]     v_prev;
  logic [MV_W-1:0]     l_sel;
  logic [MV_W-1:0]     l_prev;
  logic [MV_W:0]       dl;
  logic [MV_W:0]       dl_mag;
  logic [MV_W+1:0]     sum;
  logic                at_first;
  logic                at_last;
  logic                seg_hit;

  bvcl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_scale_q16    <= SCALE_RESET;
      low_threshold_mv  <= '0;
      volt_points_low   <= '0;
      volt_points_high  <= '0;
      level_points_low  <= '0;
      level_points_high <= '0;
      points_used       <= POINTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLT_SCALE:  volt_scale_q16    <= cfg_data[SCALE_W-1:0];
        REG_LOW_THRESH:  low_threshold_mv  <= cfg_data[MV_W-1:0];
        REG_VOLT_LOW:    volt_points_low   <= cfg_data;
        REG_VOLT_HIGH:   volt_points_high  <= cfg_data;
        REG_LEVEL_LOW:   level_points_low  <= cfg_data;
        REG_LEVEL_HIGH:  level_points_high <= cfg_data;
        REG_POINTS_USED: points_used       <= cfg_data[POINTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign idx_last = last_index(points_used);
  assign idx_prev = idx - 1'b1;
  assign v_sel    = table_entry(volt_points_low, volt_points_high, idx);
  assign v_prev   = table_entry(volt_points_low, volt_points_high, idx_prev);
  assign l_sel    = table_entry(level_points_low, level_points_high, idx);
  assign l_prev   = table_entry(level_points_low, level_points_high, idx_prev);

  assign mv_sat   = (prod[PROD_W-1:2*MV_W] != '0) ? MV_MAX : prod[2*MV_W-1:MV_W];
  assign at_first = mv_sat <= table_entry(volt_points_low, volt_points_high, '0);
  assign at_last  = mv_sat >= table_entry(volt_points_low, volt_points_high, idx_last);
  assign seg_hit  = mv <= v_sel;

  assign dl       = {1'b0, l_sel} - {1'b0, l_prev};
  assign dl_mag   = dl[MV_W] ? (~dl + 1'b1) : dl;
  assign sum      = neg ? ({2'b00, l_prev} - {2'b00, div_rsp.quotient})
                        : ({2'b00, l_prev} + {2'b00, div_rsp.quotient});

  always_comb begin
    mul_a = ch ? raw_b : raw_a;
    mul_b = volt_scale_q16;
    if (state == ST_PROD) begin
      mul_a = mv - v_prev;
      mul_b = SCALE_W'(dl_mag[MV_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    sample.ready     = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod[DIVD_W-1:0];
    div_req.divisor  = den;
    case (state)
      ST_IDLE: begin
        sample.ready = !rst;
        if (sample.valid) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_next = ST_CLASS;
      end
      ST_CLASS: begin
        if (at_first || at_last) begin
          state_next = ST_STORE;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (seg_hit) begin
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (!ch) begin
          state_next = ST_SCALE;
        end else if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ch    <= 1'b0;
        raw_a <= sample.raw_a;
        raw_b <= sample.raw_b;
      end
      ST_SCALE: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      ST_CLASS: begin
        mv  <= mv_sat;
        idx <= PT_IDX_W'(1);
        lvl <= at_first ? LEVEL_EMPTY : LEVEL_FULL;
      end
      ST_SEARCH: begin
        if (!seg_hit) begin
          idx <= idx + 1'b1;
        end
      end
      ST_PROD: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        den  <= v_sel - v_prev;
        neg  <= dl[MV_W];
      end
      ST_DIV: begin
        if (sum[MV_W+1]) begin
          lvl <= LEVEL_EMPTY;
        end else if (sum > (MV_W+2)'(LEVEL_FULL)) begin
          lvl <= LEVEL_FULL;
        end else begin
          lvl <= sum[LEVEL_W-1:0];
        end
      end
      ST_STORE: begin
        if (!ch) begin
          ch       <= 1'b1;
          keep_mv  <= mv;
          keep_lvl <= lvl;
          keep_low <= mv < low_threshold_mv;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.volts_a_mv <= keep_mv;
      result.level_a    <= keep_lvl;
      result.low_a      <= keep_low;
      result.volts_b_mv <= mv;
      result.level_b    <= lvl;
      result.low_b      <= mv < low_threshold_mv;
    end
  end

  assign result.valid = out_valid;

`ifndef SYNTH
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (idx <= idx_last) && (idx != '0))
    else $error("Breakpoint search ran past the last point in use.");

  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("Divider finished outside the divide wait state.");

  a_div_to_store: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && div_rsp.done |=> (state == ST_STORE) && (lvl <= LEVEL_FULL))
    else $error("Interpolated level was not stored after the divide.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || result.ready) && ch)
    else $error("Result register loaded while a result still waited.");
`endif

endmodule
